FILE: rtl/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants of the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

   // residue and modulus width, shared unit width, shift/bit counter width
   localparam int MOD_W = 31;
   localparam int ALU_W = MOD_W + 1;
   localparam int SH_W  = 5;

   // request actions
   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_SUB = 2'd1;
   localparam logic [1:0] ACT_MUL = 2'd2;
   localparam logic [1:0] ACT_INV = 2'd3;

   // shared unit: value = (x + y >= z) ? x + y - z : x + y
   typedef struct packed {
      logic [ALU_W-1:0] x;
      logic [ALU_W-1:0] y;
      logic [ALU_W-1:0] z;
   } alu_in_type;

   typedef struct packed {
      logic [ALU_W-1:0] value;
      logic             ge;
   } alu_out_type;

   typedef struct packed {
      logic [MOD_W-1:0] residue;
      logic             status;
   } result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_stat_type;

endpackage

FILE: rtl/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular add, subtract, multiply and inverse over a per-request modulus.
// ----------------------------------------------------------------------------
// each request carries an action, a modulus m and two signed operands, and
// gives one response: the canonical residue in 0..m-1 of the sum, difference
// or product, or for the inverse action the inverse of the left operand mod m
// (extended euclid), with status set and residue zero when the gcd is not 1.
// a zero modulus answers at once with residue zero (status set only for the
// inverse). all work runs through one shared add/compare/subtract unit, one
// operation per clock, so one request is in flight at a time and req_ready is
// low while it runs. the multiply doubles and conditionally adds once per
// modulus bit, and the inverse runs a shift-and-subtract division for each
// euclid quotient step. a finished response sits in the output register, so
// a new request is taken while the previous response still waits on rsp_ready
module modular_arithmetic_unit #(
   parameter int WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_action,
   input  logic [mau_pkg::MOD_W-1:0]     req_modulus,
   input  logic signed [WIDTH-1:0]       req_left_operand,
   input  logic signed [WIDTH-1:0]       req_right_operand,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mau_pkg::MOD_W-1:0]     rsp_residue,
   output logic                          rsp_status
);

   mau_pkg::core_stat_type   core_stat;
   mau_pkg::result_type      core_result;
   logic                     start;
   logic                     take;

   logic                     rsp_valid_ff, rsp_valid_in;
   mau_pkg::result_type      rsp_data_ff, rsp_data_in;

   // a request is taken only while the sequencer is idle
   assign req_ready = core_stat.idle;
   assign start     = req_valid & req_ready;

   // move a finished result once the output register is free or draining
   assign take = core_stat.done & (~rsp_valid_ff | rsp_ready);

   mau_core #(
      .WIDTH (WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .take          (take),
      .action        (req_action),
      .modulus       (req_modulus),
      .left_operand  (req_left_operand),
      .right_operand (req_right_operand),
      .stat          (core_stat),
      .result        (core_result)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_residue = rsp_data_ff.residue;
   assign rsp_status  = rsp_data_ff.status;

endmodule

FILE: rtl/mau_alu.sv
// ----------------------------------------------------------------------------
// mau_alu
// Shared add, compare and conditional subtract unit.
// ----------------------------------------------------------------------------
module mau_alu (
   input  mau_pkg::alu_in_type  op_in,
   output mau_pkg::alu_out_type op_out
);

   logic [mau_pkg::ALU_W:0] sum;
   logic [mau_pkg::ALU_W:0] diff;
   logic                    ge;

   always_comb begin
      sum  = {1'b0, op_in.x} + {1'b0, op_in.y};
      ge   = (sum >= {1'b0, op_in.z});
      diff = sum - {1'b0, op_in.z};
      op_out.ge    = ge;
      op_out.value = ge ? diff[mau_pkg::ALU_W-1:0] : sum[mau_pkg::ALU_W-1:0];
   end

endmodule

FILE: rtl/mau_core.sv
// ----------------------------------------------------------------------------
// mau_core
// Sequencer and working registers around the shared unit: operand reduction,
// add, subtract, shift-add multiply and extended Euclid inverse.
// ----------------------------------------------------------------------------
module mau_core #(
   parameter int WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           take,
   input  logic [1:0]                     action,
   input  logic [mau_pkg::MOD_W-1:0]      modulus,
   input  logic signed [WIDTH-1:0]        left_operand,
   input  logic signed [WIDTH-1:0]        right_operand,
   output mau_pkg::core_stat_type         stat,
   output mau_pkg::result_type            result
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);
   localparam logic [mau_pkg::SH_W-1:0] MUL_LAST = mau_pkg::SH_W'(mau_pkg::MOD_W - 1);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RED_L = 5'd1;
   localparam logic [4:0] S_FIX_L = 5'd2;
   localparam logic [4:0] S_RED_R = 5'd3;
   localparam logic [4:0] S_FIX_R = 5'd4;
   localparam logic [4:0] S_NEGY  = 5'd5;
   localparam logic [4:0] S_ADD   = 5'd6;
   localparam logic [4:0] S_M_DBL = 5'd7;
   localparam logic [4:0] S_M_ADD = 5'd8;
   localparam logic [4:0] S_E_CHK = 5'd9;
   localparam logic [4:0] S_E_UP  = 5'd10;
   localparam logic [4:0] S_E_DIV = 5'd11;
   localparam logic [4:0] S_E_DBL = 5'd12;
   localparam logic [4:0] S_E_ADD = 5'd13;
   localparam logic [4:0] S_E_NEG = 5'd14;
   localparam logic [4:0] S_E_SUB = 5'd15;
   localparam logic [4:0] S_DONE  = 5'd16;

   localparam int MW = mau_pkg::MOD_W;
   localparam int AW = mau_pkg::ALU_W;

   logic [4:0]                 state_ff, state_in;
   logic [1:0]                 act_ff, act_in;
   logic [MW-1:0]              m_ff, m_in;
   logic [WIDTH-1:0]           lmag_ff, lmag_in;
   logic [WIDTH-1:0]           rmag_ff, rmag_in;
   logic                       lneg_ff, lneg_in;
   logic                       rneg_ff, rneg_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [mau_pkg::SH_W-1:0]   sh_ff, sh_in;
   logic [MW-1:0]              xr_ff, xr_in;
   logic [MW-1:0]              yr_ff, yr_in;
   logic [MW-1:0]              acc_ff, acc_in;
   logic [MW-1:0]              a_ff, a_in;
   logic [MW-1:0]              b_ff, b_in;
   logic [MW-1:0]              wa_ff, wa_in;
   logic [MW-1:0]              bs_ff, bs_in;
   logic [MW-1:0]              t_ff, t_in;
   logic [MW-1:0]              tn_ff, tn_in;
   logic                       qb_ff, qb_in;
   mau_pkg::result_type        res_ff, res_in;

   logic [WIDTH-1:0]           lop_u;
   logic [WIDTH-1:0]           rop_u;
   mau_pkg::alu_in_type        alu_in;
   mau_pkg::alu_out_type       alu_out;
   logic [MW-1:0]              alu_val;

   mau_alu u_alu (
      .op_in  (alu_in),
      .op_out (alu_out)
   );

   assign alu_val = alu_out.value[MW-1:0];
   assign lop_u   = left_operand;
   assign rop_u   = right_operand;

   // operand selection for the shared unit
   always_comb begin
      alu_in = '0;
      unique case (state_ff)
         S_RED_L: begin
            alu_in.x = {xr_ff, lmag_ff[WIDTH-1]};
            alu_in.z = AW'(m_ff);
         end
         S_FIX_L: begin
            alu_in.x = AW'(m_ff);
            alu_in.z = AW'(xr_ff);
         end
         S_RED_R: begin
            alu_in.x = {yr_ff, rmag_ff[WIDTH-1]};
            alu_in.z = AW'(m_ff);
         end
         S_FIX_R, S_NEGY: begin
            alu_in.x = AW'(m_ff);
            alu_in.z = AW'(yr_ff);
         end
         S_ADD: begin
            alu_in.x = AW'(xr_ff);
            alu_in.y = AW'(yr_ff);
            alu_in.z = AW'(m_ff);
         end
         S_M_DBL, S_E_DBL: begin
            alu_in.x = AW'(acc_ff);
            alu_in.y = AW'(acc_ff);
            alu_in.z = AW'(m_ff);
         end
         S_M_ADD: begin
            alu_in.x = AW'(acc_ff);
            alu_in.y = AW'(xr_ff);
            alu_in.z = AW'(m_ff);
         end
         S_E_UP: begin
            alu_in.x = AW'(wa_ff);
            alu_in.z = {bs_ff, 1'b0};
         end
         S_E_DIV: begin
            alu_in.x = AW'(wa_ff);
            alu_in.z = AW'(bs_ff);
         end
         S_E_ADD: begin
            alu_in.x = AW'(acc_ff);
            alu_in.y = AW'(tn_ff);
            alu_in.z = AW'(m_ff);
         end
         S_E_NEG: begin
            alu_in.x = AW'(m_ff);
            alu_in.z = AW'(acc_ff);
         end
         S_E_SUB: begin
            alu_in.x = AW'(t_ff);
            alu_in.y = AW'(acc_ff);
            alu_in.z = AW'(m_ff);
         end
         default: alu_in = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      m_in     = m_ff;
      lmag_in  = lmag_ff;
      rmag_in  = rmag_ff;
      lneg_in  = lneg_ff;
      rneg_in  = rneg_ff;
      cnt_in   = cnt_ff;
      sh_in    = sh_ff;
      xr_in    = xr_ff;
      yr_in    = yr_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      wa_in    = wa_ff;
      bs_in    = bs_ff;
      t_in     = t_ff;
      tn_in    = tn_ff;
      qb_in    = qb_ff;
      res_in   = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in  = action;
               m_in    = modulus;
               lneg_in = lop_u[WIDTH-1];
               rneg_in = rop_u[WIDTH-1];
               lmag_in = lop_u[WIDTH-1] ? (~lop_u + 1'b1) : lop_u;
               rmag_in = rop_u[WIDTH-1] ? (~rop_u + 1'b1) : rop_u;
               xr_in   = '0;
               yr_in   = '0;
               cnt_in  = CNT_LAST;
               if (modulus == '0) begin
                  res_in.residue = '0;
                  res_in.status  = (action == mau_pkg::ACT_INV);
                  state_in       = S_DONE;
               end else begin
                  state_in = S_RED_L;
               end
            end
         end
         S_RED_L: begin
            xr_in   = alu_val;
            lmag_in = lmag_ff << 1;
            if (cnt_ff == '0) begin
               cnt_in   = CNT_LAST;
               state_in = S_FIX_L;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_FIX_L: begin
            if (lneg_ff && (xr_ff != '0)) begin
               xr_in = alu_val;
            end
            state_in = S_RED_R;
         end
         S_RED_R: begin
            yr_in   = alu_val;
            rmag_in = rmag_ff << 1;
            if (cnt_ff == '0) begin
               state_in = S_FIX_R;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_FIX_R: begin
            if (rneg_ff && (yr_ff != '0)) begin
               yr_in = alu_val;
            end
            acc_in = '0;
            sh_in  = MUL_LAST;
            a_in   = m_ff;
            b_in   = xr_ff;
            t_in   = '0;
            tn_in  = (m_ff == MW'(1)) ? '0 : MW'(1);
            unique case (act_ff)
               mau_pkg::ACT_ADD: state_in = S_ADD;
               mau_pkg::ACT_SUB: state_in = S_NEGY;
               mau_pkg::ACT_MUL: state_in = S_M_DBL;
               mau_pkg::ACT_INV: state_in = S_E_CHK;
               default:          state_in = S_ADD;
            endcase
         end
         S_NEGY: begin
            // m - y, which is m itself when y is zero
            yr_in    = alu_val;
            state_in = S_ADD;
         end
         S_ADD: begin
            res_in.residue = alu_val;
            res_in.status  = 1'b0;
            state_in       = S_DONE;
         end
         S_M_DBL: begin
            acc_in   = alu_val;
            state_in = S_M_ADD;
         end
         S_M_ADD: begin
            if (yr_ff[MW-1]) begin
               acc_in = alu_val;
            end
            yr_in = yr_ff << 1;
            if (sh_ff == '0) begin
               res_in.residue = yr_ff[MW-1] ? alu_val : acc_ff;
               res_in.status  = 1'b0;
               state_in       = S_DONE;
            end else begin
               sh_in    = sh_ff - 1'b1;
               state_in = S_M_DBL;
            end
         end
         S_E_CHK: begin
            if (b_ff == '0) begin
               if (a_ff == MW'(1)) begin
                  res_in.residue = t_ff;
                  res_in.status  = 1'b0;
               end else begin
                  res_in.residue = '0;
                  res_in.status  = 1'b1;
               end
               state_in = S_DONE;
            end else begin
               wa_in    = a_ff;
               bs_in    = b_ff;
               sh_in    = '0;
               acc_in   = '0;
               state_in = S_E_UP;
            end
         end
         S_E_UP: begin
            // align divisor under the top of the dividend
            if (alu_out.ge) begin
               bs_in = bs_ff << 1;
               sh_in = sh_ff + 1'b1;
            end else begin
               state_in = S_E_DIV;
            end
         end
         S_E_DIV: begin
            qb_in = alu_out.ge;
            if (alu_out.ge) begin
               wa_in = alu_val;
            end
            state_in = S_E_DBL;
         end
         S_E_DBL: begin
            acc_in   = alu_val;
            state_in = S_E_ADD;
         end
         S_E_ADD: begin
            if (qb_ff) begin
               acc_in = alu_val;
            end
            if (sh_ff == '0) begin
               state_in = S_E_NEG;
            end else begin
               bs_in    = bs_ff >> 1;
               sh_in    = sh_ff - 1'b1;
               state_in = S_E_DIV;
            end
         end
         S_E_NEG: begin
            acc_in   = alu_val;
            state_in = S_E_SUB;
         end
         S_E_SUB: begin
            t_in     = tn_ff;
            tn_in    = alu_val;
            a_in     = b_ff;
            b_in     = wa_ff;
            state_in = S_E_CHK;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      act_ff  <= act_in;
      m_ff    <= m_in;
      lmag_ff <= lmag_in;
      rmag_ff <= rmag_in;
      lneg_ff <= lneg_in;
      rneg_ff <= rneg_in;
      cnt_ff  <= cnt_in;
      sh_ff   <= sh_in;
      xr_ff   <= xr_in;
      yr_ff   <= yr_in;
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      wa_ff   <= wa_in;
      bs_ff   <= bs_in;
      t_ff    <= t_in;
      tn_ff   <= tn_in;
      qb_ff   <= qb_in;
      res_ff  <= res_in;
   end

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_DONE);
   assign result    = res_ff;

`ifndef NO_ASSERTIONS
   // a finished result stays until the top level takes it
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !take) |=> (state_ff == S_DONE))
      else $error("result dropped before it was taken");

   // only the inverse can report a missing inverse
   a_status_inv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_ff.status) |-> (act_ff == mau_pkg::ACT_INV))
      else $error("no-inverse status on a non-inverse action");

   // a missing inverse always comes with a zero residue
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_ff.status) |-> (res_ff.residue == '0))
      else $error("non-zero residue with no-inverse status");

   // results are canonical
   a_canonical: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && m_ff != '0) |-> (res_ff.residue < m_ff))
      else $error("residue not below modulus");

   // accumulator stays reduced in the multiply and while the quotient is folded in
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_E_DBL || state_ff == S_M_DBL) |-> (acc_ff < m_ff))
      else $error("accumulator left its residue range");
`endif

endmodule
